// ===== rtl/brf_pkg.sv =====
package brf_pkg;

	localparam int DEPTH = 256;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = AW + 1;

	typedef enum logic [2:0] {
		KIND_PUSH  = 3'd0,
		KIND_POP   = 3'd1,
		KIND_PEEK  = 3'd2,
		KIND_COUNT = 3'd3,
		KIND_INIT  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CNT  = 9'b000000010,
		S_FIX  = 9'b000000100,
		S_CHK  = 9'b000001000,
		S_ADDR = 9'b000010000,
		S_WRAP = 9'b000100000,
		S_MEM  = 9'b001000000,
		S_NEWC = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic          clr;
		logic          we;
		logic          re;
		logic [AW-1:0] addr;
		logic [7:0]    wdata;
	} store_ctl_t;

	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] v);
		logic [SW-1:0] s;
		s = v;
		if (v < SW'(3)) begin
			s = SW'(3);
		end
		if (v > SW'(DEPTH)) begin
			s = SW'(DEPTH);
		end
		return s;
	endfunction

endpackage

// ===== rtl/byte_ring_fifo.sv =====
// Byte FIFO in a ring of programmable size. A transaction is taken when start is high and busy
// is low; its result appears for exactly one cycle with done high and must be captured then.
// Transaction arithmetic runs through one shared 9-bit adder under a small sequencer, one pass
// per cycle. It forms the count, fixed up if the write pointer is behind the read pointer,
// and checks it; a push, pop or peek that passes forms and wraps the address and uses the
// store, while a refused push, a pop or peek finding too few entries, a count query, init or
// an unknown kind skips to the new count. Busy drops the cycle after done. Init clears the whole
// store at once. Writing ring_size empties the FIFO and must only happen while busy is low.
module byte_ring_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [brf_pkg::SW-1:0] cfg_data,
	input  logic                   start,
	output logic                   busy,
	input  logic [2:0]             kind,
	input  logic [7:0]             data_in,
	input  logic [7:0]             peek_offset,
	output logic                   done,
	output logic [7:0]             data_out,
	output logic [1:0]             status,
	output logic [7:0]             fill_count
);
	import brf_pkg::*;

	state_t        state_q, state_d;
	logic [2:0]    kind_q;
	logic [7:0]    din_q;
	logic [7:0]    off_q;
	logic [AW-1:0] head_q, tail_q, addr_q;
	logic [SW-1:0] sz_q, lim_q, tmp_q;
	logic [7:0]    cnt_q;
	logic          ok_q;
	status_t       st_q;

	logic [SW-1:0] alu_a, alu_b;
	alu_op_t       alu_op;
	logic [SW:0]   alu_res;
	store_ctl_t    sctl;
	logic [7:0]    rdata;
	logic          is_push, is_pop, is_peek, is_init;

	assign is_push = (kind_q == KIND_PUSH);
	assign is_pop  = (kind_q == KIND_POP);
	assign is_peek = (kind_q == KIND_PEEK);
	assign is_init = (kind_q == KIND_INIT);

	brf_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.res(alu_res)
	);

	brf_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (sctl),
		.rdata (rdata)
	);

	always_comb begin
		alu_a  = '0;
		alu_b  = '0;
		alu_op = ALU_ADD;
		case (state_q)
			S_CNT: begin
				alu_a  = {1'b0, tail_q};
				alu_b  = {1'b0, head_q};
				alu_op = ALU_SUB;
			end
			S_FIX: begin
				alu_a = tmp_q;
				alu_b = sz_q;
			end
			S_CHK: begin
				alu_op = ALU_SUB;
				if (is_push) begin
					alu_a = {1'b0, cnt_q};
					alu_b = lim_q;
				end else if (is_peek) begin
					alu_a = {1'b0, off_q};
					alu_b = {1'b0, cnt_q};
				end else begin
					alu_a = {1'b0, cnt_q};
					alu_b = SW'(1);
				end
			end
			S_ADDR: begin
				alu_a = is_push ? {1'b0, tail_q} : {1'b0, head_q};
				alu_b = is_peek ? {1'b0, off_q} : SW'(1);
			end
			S_WRAP: begin
				alu_a  = tmp_q;
				alu_b  = sz_q;
				alu_op = ALU_SUB;
			end
			S_NEWC: begin
				alu_a  = {1'b0, cnt_q};
				alu_b  = (ok_q && (is_push || is_pop)) ? SW'(1) : SW'(0);
				alu_op = is_pop ? ALU_SUB : ALU_ADD;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		sctl.clr   = (state_q == S_NEWC) && is_init;
		sctl.we    = (state_q == S_MEM) && is_push;
		sctl.re    = (state_q == S_MEM) && !is_push;
		sctl.wdata = din_q;
		if (is_push) begin
			sctl.addr = tail_q;
		end else if (is_pop) begin
			sctl.addr = head_q;
		end else begin
			sctl.addr = addr_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_CNT;
			S_CNT:  state_d = alu_res[SW] ? S_FIX : S_CHK;
			S_FIX:  state_d = S_CHK;
			S_CHK: begin
				if ((is_push && alu_res[SW]) || (is_pop && !alu_res[SW])
						|| (is_peek && alu_res[SW])) begin
					state_d = S_ADDR;
				end else begin
					state_d = S_NEWC;
				end
			end
			S_ADDR: state_d = S_WRAP;
			S_WRAP: state_d = S_MEM;
			S_MEM:  state_d = S_NEWC;
			S_NEWC: state_d = S_OUT;
			S_OUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			sz_q    <= SW'(DEPTH);
			lim_q   <= SW'(DEPTH - 2);
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sz_q   <= eff_size(cfg_data);
				lim_q  <= eff_size(cfg_data) - SW'(2);
				head_q <= '0;
				tail_q <= '0;
			end else if (state_q == S_MEM) begin
				if (is_push) begin
					tail_q <= addr_q;
				end else if (is_pop) begin
					head_q <= addr_q;
				end
			end else if (state_q == S_NEWC && is_init) begin
				head_q <= '0;
				tail_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q <= kind;
				din_q  <= data_in;
				off_q  <= peek_offset;
			end
			S_CNT: begin
				tmp_q <= alu_res[SW-1:0];
				cnt_q <= alu_res[7:0];
			end
			S_FIX: cnt_q <= alu_res[7:0];
			S_CHK: begin
				ok_q <= 1'b0;
				st_q <= ST_OK;
				if (is_push) begin
					ok_q <= alu_res[SW];
					st_q <= alu_res[SW] ? ST_OK : ST_OVERFLOW;
				end else if (is_pop) begin
					ok_q <= !alu_res[SW];
					st_q <= alu_res[SW] ? ST_EMPTY : ST_OK;
				end else if (is_peek) begin
					ok_q <= alu_res[SW];
					st_q <= alu_res[SW] ? ST_OK : ST_EMPTY;
				end
			end
			S_ADDR: tmp_q <= alu_res[SW-1:0];
			S_WRAP: addr_q <= alu_res[SW] ? tmp_q[AW-1:0] : alu_res[AW-1:0];
			S_NEWC: cnt_q <= is_init ? 8'd0 : alu_res[7:0];
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_OUT);
	assign data_out   = (ok_q && (is_pop || is_peek)) ? rdata : 8'd0;
	assign status     = st_q;
	assign fill_count = cnt_q;

endmodule

// ===== rtl/brf_alu.sv =====
module brf_alu (
	input  logic [brf_pkg::SW-1:0] a,
	input  logic [brf_pkg::SW-1:0] b,
	input  brf_pkg::alu_op_t       op,
	output logic [brf_pkg::SW:0]   res
);
	import brf_pkg::*;

	// The top bit is the carry on an add and the borrow on a subtract.
	always_comb begin
		if (op == ALU_SUB) begin
			res = {1'b0, a} - {1'b0, b};
		end else begin
			res = {1'b0, a} + {1'b0, b};
		end
	end

endmodule

// ===== rtl/brf_store.sv =====
module brf_store (
	input  logic                clk,
	input  logic                arst_n,
	input  brf_pkg::store_ctl_t ctl,
	output logic [7:0]          rdata
);
	import brf_pkg::*;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rdata_q;

	// An entry that has not been written since reset or the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.we) begin
			valid_q[ctl.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.addr] <= ctl.wdata;
		end
		if (ctl.re) begin
			rdata_q <= valid_q[ctl.addr] ? mem[ctl.addr] : 8'd0;
		end
	end

	assign rdata = rdata_q;

endmodule
